@@ src/mpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants for the multichannel PWM with fade core.
// ----------------------------------------------------------------------------
package mpwm_pkg;

   // channel count limits
   localparam int MAX_CHANNELS = 8;
   localparam int CHANNELS_DEF = 8;

   // field widths
   localparam int CMD_W   = 2;
   localparam int PIN_W   = 3;
   localparam int DUTY_W  = 8;
   localparam int COUNT_W = 8;
   localparam int LEVEL_W = 8;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK = 2'd0,
      CMD_FADE = 2'd1,
      CMD_SET  = 2'd2,
      CMD_GOAL = 2'd3
   } cmd_type;

   // control broadcast from the top level to every channel lane
   typedef struct packed {
      logic               tick;
      logic               fade;
      logic               set_duty;
      logic               set_goal;
      logic [DUTY_W-1:0]  duty;
      logic [COUNT_W-1:0] period;
   } lane_ctrl_type;

endpackage

@@ src/mpwm_req_if.sv @@
// ----------------------------------------------------------------------------
// mpwm_req_if
// Command channel: valid/ready handshake carrying cmd, pin and duty.
// ----------------------------------------------------------------------------
interface mpwm_req_if;
   logic                        valid;
   logic                        ready;
   logic [mpwm_pkg::CMD_W-1:0]  cmd;
   logic [mpwm_pkg::PIN_W-1:0]  pin;
   logic [mpwm_pkg::DUTY_W-1:0] duty;

   modport source (output valid, output cmd, output pin, output duty, input ready);
   modport sink   (input valid, input cmd, input pin, input duty, output ready);
endinterface

@@ src/mpwm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mpwm_rsp_if
// Response channel: valid/ready handshake carrying the pin levels.
// ----------------------------------------------------------------------------
interface mpwm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mpwm_pkg::LEVEL_W-1:0] pin_levels;

   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface

@@ src/mpwm_lane.sv @@
// ----------------------------------------------------------------------------
// mpwm_lane
// One PWM channel: current duty, fade target and the period compare.
// ----------------------------------------------------------------------------
module mpwm_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  mpwm_pkg::lane_ctrl_type ctrl,
   input  logic                    sel,
   output logic                    level
);

   logic [mpwm_pkg::DUTY_W-1:0] duty_now_ff, duty_now_in;
   logic [mpwm_pkg::DUTY_W-1:0] duty_goal_ff, duty_goal_in;

   // write, set or step the duty toward its target
   always_comb begin
      duty_now_in  = duty_now_ff;
      duty_goal_in = duty_goal_ff;
      if (ctrl.set_duty && sel) begin
         duty_now_in  = ctrl.duty;
         duty_goal_in = ctrl.duty;
      end else if (ctrl.set_goal && sel) begin
         duty_goal_in = ctrl.duty;
      end else if (ctrl.fade) begin
         if (duty_now_ff < duty_goal_ff) begin
            duty_now_in = duty_now_ff + 1'b1;
         end else if (duty_now_ff > duty_goal_ff) begin
            duty_now_in = duty_now_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_now_ff  <= '0;
         duty_goal_ff <= '0;
      end else begin
         duty_now_ff  <= duty_now_in;
         duty_goal_ff <= duty_goal_in;
      end
   end

   // pin is high while the advanced count is at most the duty
   assign level = (ctrl.period <= duty_now_ff);

endmodule

@@ src/multichannel_pwm_with_fade_core.sv @@
// ----------------------------------------------------------------------------
// multichannel_pwm_with_fade_core
// Multichannel PWM with per-channel duty, fade target and shared counter.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one command word: cmd (tick, fade step, set duty, fade to
//   duty), pin and duty. rsp_if returns one word per command: pin_levels,
//   the registered pin levels after that command (bit i is channel i, bits
//   at or above CHANNELS read 0).
//   A word accepted at one edge is on rsp_if from the next cycle.
//   Throughput is one word per cycle while rsp_if is not stalled; the
//   channel lanes update in parallel, so the per-item cost is one compare
//   or increment per lane. rsp_if holds its word in the level register;
//   req_if.ready stays high while that register is empty or being taken,
//   so a stalled receiver holds the response and blocks only new commands.
//   Set and fade commands change duties only; pins follow at the next tick.
//   Reset clears the period counter, all duties, targets and pin levels
//   and leaves the response channel empty.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_fade_core #(
   parameter int CHANNELS = mpwm_pkg::CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mpwm_req_if.sink   req_if,
   mpwm_rsp_if.source rsp_if
);

   localparam logic [mpwm_pkg::LEVEL_W-1:0] LANE_MASK =
      mpwm_pkg::LEVEL_W'((9'd1 << CHANNELS) - 9'd1);
   localparam logic [mpwm_pkg::PIN_W:0] PIN_LIMIT = (mpwm_pkg::PIN_W+1)'(CHANNELS);

   mpwm_pkg::cmd_type             cmd;
   mpwm_pkg::lane_ctrl_type       ctrl;
   logic                          accept;
   logic                          pin_ok;
   logic [mpwm_pkg::COUNT_W-1:0]  period_ff, period_in;
   logic [mpwm_pkg::LEVEL_W-1:0]  level_bits_ff, level_bits_in;
   logic [mpwm_pkg::LEVEL_W-1:0]  lane_level;
   logic                          rsp_valid_ff, rsp_valid_in;

   // take a word whenever the response register is free or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign cmd          = mpwm_pkg::cmd_type'(req_if.cmd);
   assign pin_ok       = ({1'b0, req_if.pin} < PIN_LIMIT);

   // advance the shared counter on a tick
   assign period_in = (accept && cmd == mpwm_pkg::CMD_TICK) ? period_ff + 1'b1 : period_ff;

   // broadcast lane control
   always_comb begin
      ctrl.tick     = accept && cmd == mpwm_pkg::CMD_TICK;
      ctrl.fade     = accept && cmd == mpwm_pkg::CMD_FADE;
      ctrl.set_duty = accept && cmd == mpwm_pkg::CMD_SET && pin_ok;
      ctrl.set_goal = accept && cmd == mpwm_pkg::CMD_GOAL && pin_ok;
      ctrl.duty     = req_if.duty;
      ctrl.period   = period_in;
   end

   // one lane per live channel, unused bits read low
   for (genvar i = 0; i < mpwm_pkg::MAX_CHANNELS; i++) begin : g_lane
      if (i < CHANNELS) begin : g_live
         mpwm_lane u_lane (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .sel   (req_if.pin == mpwm_pkg::PIN_W'(i)),
            .level (lane_level[i])
         );
      end else begin : g_unused
         assign lane_level[i] = 1'b0;
      end
   end

   // latch pin levels on a tick, hold otherwise
   assign level_bits_in = ctrl.tick ? lane_level : level_bits_ff;

   // hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= '0;
         level_bits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         level_bits_ff <= level_bits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pin_levels = level_bits_ff;

   // every accepted word produces a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("response missing after accepted word");

   // only a tick may change the pin levels
   a_levels_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd != mpwm_pkg::CMD_TICK) |=> $stable(level_bits_ff))
      else $error("pin levels changed without a tick");

   // the counter wrap drives every live channel high
   a_wrap_high: assert property (@(posedge clock) disable iff (reset)
      (ctrl.tick && period_ff == '1) |=> (level_bits_ff == LANE_MASK))
      else $error("not all channels high at counter wrap");

   // unused channels never drive high
   a_unused_low: assert property (@(posedge clock) disable iff (reset)
      (level_bits_ff & ~LANE_MASK) == '0)
      else $error("unused channel driven high");

endmodule

@@ tb/multichannel_pwm_with_fade_core_test.sv @@
// ----------------------------------------------------------------------------
// multichannel_pwm_with_fade_core_test
// Self-checking testbench for the multichannel PWM with fade core. Commands
// go in through the request channel with random gaps. Each response word is
// taken with random stalls and compared with the pin levels worked out by a
// local model of the counter, the duties and the fade targets.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_fade_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS   = mpwm_pkg::CHANNELS_DEF;
   localparam int IDLE_LIMIT = 1000;
   localparam int DRAIN_WAIT = 4;

   logic clock;
   logic reset;

   mpwm_req_if req_ch ();
   mpwm_rsp_if rsp_ch ();

   multichannel_pwm_with_fade_core #(
      .CHANNELS (CHANNELS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // model state of the PWM block
   logic [mpwm_pkg::COUNT_W-1:0] model_count;
   logic [mpwm_pkg::DUTY_W-1:0]  model_duty [mpwm_pkg::MAX_CHANNELS];
   logic [mpwm_pkg::DUTY_W-1:0]  model_goal [mpwm_pkg::MAX_CHANNELS];
   logic [mpwm_pkg::LEVEL_W-1:0] model_levels;

   logic [mpwm_pkg::LEVEL_W-1:0] pending_levels [$];
   int                           mismatch_count;
   int                           send_gap_max;
   int                           rsp_stall_max;
   int                           idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // advance the model by one command, return the pin levels after it
   function automatic logic [mpwm_pkg::LEVEL_W-1:0] predict_pin_levels(
         mpwm_pkg::cmd_type c,
         logic [mpwm_pkg::PIN_W-1:0] p,
         logic [mpwm_pkg::DUTY_W-1:0] d);
      logic [mpwm_pkg::LEVEL_W-1:0] lv;
      lv = '0;
      case (c)
         mpwm_pkg::CMD_TICK: begin
            model_count = model_count + 1'b1;
            for (int i = 0; i < CHANNELS; i++)
               if (model_count <= model_duty[i]) lv[i] = 1'b1;
            model_levels = lv;
         end
         mpwm_pkg::CMD_FADE: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (model_duty[i] < model_goal[i])
                  model_duty[i] = model_duty[i] + 1'b1;
               else if (model_duty[i] > model_goal[i])
                  model_duty[i] = model_duty[i] - 1'b1;
            end
         end
         mpwm_pkg::CMD_SET: begin
            if (int'(p) < CHANNELS) begin
               model_duty[p] = d;
               model_goal[p] = d;
            end
         end
         default: begin
            if (int'(p) < CHANNELS) model_goal[p] = d;
         end
      endcase
      return model_levels;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // drive one word after a random gap, hold it until taken, then predict
   task automatic send_command(mpwm_pkg::cmd_type c, logic [mpwm_pkg::PIN_W-1:0] p,
                               logic [mpwm_pkg::DUTY_W-1:0] d);
      int gap;
      gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= c;
      req_ch.pin   <= p;
      req_ch.duty  <= d;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_levels.push_back(predict_pin_levels(c, p, d));
   endtask

   // weighted command pick: ticks most often so the counter keeps moving
   function automatic mpwm_pkg::cmd_type pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return mpwm_pkg::CMD_TICK;
      if (r < 65) return mpwm_pkg::CMD_FADE;
      if (r < 80) return mpwm_pkg::CMD_SET;
      return mpwm_pkg::CMD_GOAL;
   endfunction

   function automatic logic [mpwm_pkg::DUTY_W-1:0] pick_duty();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return model_count + 1'b1;
         default: return mpwm_pkg::DUTY_W'($urandom);
      endcase
   endfunction

   // draw one of four idle modes: both sides, sender only, receiver only, none
   task automatic set_idle_mode();
      int m;
      m = $urandom_range(0, 3);
      send_gap_max  = (m == 0 || m == 1) ? 16 : 0;
      rsp_stall_max = (m == 0 || m == 2) ? 16 : 0;
   endtask

   // check each response word against the oldest expectation
   initial begin : rsp_side
      int                           stall;
      logic [mpwm_pkg::LEVEL_W-1:0] want;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = (rsp_stall_max > 0) ? $urandom_range(0, rsp_stall_max) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (pending_levels.size() == 0) begin
            report_mismatch($sformatf("word %h with none expected", rsp_ch.pin_levels));
         end else begin
            want = pending_levels.pop_front();
            if (rsp_ch.pin_levels !== want)
               report_mismatch($sformatf("pin_levels %h, expected %h",
                                         rsp_ch.pin_levels, want));
         end
      end
   end

   // end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // field extremes, every command, ignored fields, late pin update
   task automatic test_directed();
      send_command(mpwm_pkg::CMD_TICK, 3'd0, 8'd0);
      send_command(mpwm_pkg::CMD_SET, 3'd0, 8'd255);
      send_command(mpwm_pkg::CMD_SET, 3'd7, 8'd0);
      send_command(mpwm_pkg::CMD_SET, 3'd3, 8'd1);
      send_command(mpwm_pkg::CMD_SET, 3'd5, 8'd128);
      send_command(mpwm_pkg::CMD_TICK, 3'd7, 8'd255);
      send_command(mpwm_pkg::CMD_GOAL, 3'd7, 8'd255);
      send_command(mpwm_pkg::CMD_GOAL, 3'd0, 8'd0);
      send_command(mpwm_pkg::CMD_FADE, 3'd0, 8'd0);
      send_command(mpwm_pkg::CMD_FADE, 3'd7, 8'd255);
      send_command(mpwm_pkg::CMD_TICK, 3'd0, 8'd0);
      send_command(mpwm_pkg::CMD_SET, 3'd2, 8'd2);
      send_command(mpwm_pkg::CMD_GOAL, 3'd4, 8'd3);
      send_command(mpwm_pkg::CMD_FADE, 3'd5, 8'd170);
      send_command(mpwm_pkg::CMD_TICK, 3'd2, 8'd85);
      send_command(mpwm_pkg::CMD_TICK, 3'd5, 8'd170);
      send_command(mpwm_pkg::CMD_SET, 3'd6, 8'd4);
      send_command(mpwm_pkg::CMD_FADE, 3'd1, 8'd1);
      send_command(mpwm_pkg::CMD_TICK, 3'd1, 8'd1);
   endtask

   // free mix of commands with extreme and random duties
   task automatic test_random_commands(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) set_idle_mode();
         send_command(pick_command(), mpwm_pkg::PIN_W'($urandom_range(0, 7)), pick_duty());
      end
   endtask

   // run the counter through 255 and back to 0 with duties at both ends
   task automatic test_counter_wrap();
      send_gap_max  = 0;
      rsp_stall_max = 16;
      send_command(mpwm_pkg::CMD_SET, 3'd0, 8'd0);
      send_command(mpwm_pkg::CMD_SET, 3'd1, 8'd255);
      send_command(mpwm_pkg::CMD_SET, 3'd2, 8'd254);
      do
         send_command(mpwm_pkg::CMD_TICK, 3'd0, 8'd0);
      while (model_count != '0);
      send_command(mpwm_pkg::CMD_TICK, 3'd0, 8'd0);
   endtask

   // set all channels, aim them at nearby targets, fade until they arrive
   task automatic test_fade_runs(int runs);
      int   delta;
      int   goal;
      logic settled;
      for (int r = 0; r < runs; r++) begin
         if (r % 2 == 0) begin
            send_gap_max  = 16;
            rsp_stall_max = 16;
         end else begin
            set_idle_mode();
         end
         for (int i = 0; i < mpwm_pkg::MAX_CHANNELS; i++)
            send_command(mpwm_pkg::CMD_SET, mpwm_pkg::PIN_W'(i), pick_duty());
         for (int i = 0; i < mpwm_pkg::MAX_CHANNELS; i++) begin
            delta = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 48) - 24;
            goal  = int'(model_duty[i]) + delta;
            if (goal < 0) goal = 0;
            if (goal > 255) goal = 255;
            send_command(mpwm_pkg::CMD_GOAL, mpwm_pkg::PIN_W'(i), mpwm_pkg::DUTY_W'(goal));
         end
         // fade and tick until every channel reaches its target
         settled = 1'b0;
         while (!settled) begin
            send_command(mpwm_pkg::CMD_FADE, mpwm_pkg::PIN_W'($urandom_range(0, 7)),
                         mpwm_pkg::DUTY_W'($urandom));
            send_command(mpwm_pkg::CMD_TICK, mpwm_pkg::PIN_W'($urandom_range(0, 7)),
                         mpwm_pkg::DUTY_W'($urandom));
            if ($urandom_range(0, 9) == 0)
               send_command(pick_command(), mpwm_pkg::PIN_W'($urandom_range(0, 7)),
                            pick_duty());
            settled = 1'b1;
            for (int i = 0; i < CHANNELS; i++)
               if (model_duty[i] != model_goal[i]) settled = 1'b0;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = mpwm_pkg::CMD_TICK;
      req_ch.pin     = '0;
      req_ch.duty    = '0;
      mismatch_count = 0;
      idle_cycles    = 0;
      send_gap_max   = 16;
      rsp_stall_max  = 16;
      model_count    = '0;
      model_levels   = '0;
      for (int i = 0; i < mpwm_pkg::MAX_CHANNELS; i++) begin
         model_duty[i] = '0;
         model_goal[i] = '0;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fade_runs(7);
      test_random_commands(700);
      test_counter_wrap();

      // drop valid, drain the response channel, then report the result
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
